// File: rtl/core/ogeae_pkg.sv
`default_nettype none

package ogeae_pkg;

  localparam int unsigned WordW = 12;
  localparam int unsigned ScW   = 5;
  localparam int unsigned CntW  = 5;

  // s_axis_tdata layout
  localparam int unsigned InIrLo = 0;
  localparam int unsigned InAcLo = InIrLo + WordW;
  localparam int unsigned InLkLo = InAcLo + WordW;
  localparam int unsigned InNwLo = InLkLo + 1;
  localparam int unsigned InBits = InNwLo + WordW;
  localparam int unsigned InW    = ((InBits + 7) / 8) * 8;

  // m_axis_tdata layout
  localparam int unsigned OutBits = WordW + 1 + WordW + ScW + 4;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  localparam logic [CntW-1:0] MulDivSteps = CntW'(WordW);
  localparam logic [CntW-1:0] ShlMaxSteps = CntW'(2 * WordW + 1);
  localparam logic [CntW-1:0] ShrMaxSteps = CntW'(2 * WordW);

  // Group 3 middle field, instruction bits 6..4
  localparam logic [2:0] MidNone   = 3'd0;
  localparam logic [2:0] MidMql    = 3'd1;
  localparam logic [2:0] MidSca    = 3'd2;
  localparam logic [2:0] MidScaMql = 3'd3;
  localparam logic [2:0] MidMqa    = 3'd4;
  localparam logic [2:0] MidSwp    = 3'd5;
  localparam logic [2:0] MidMqaSca = 3'd6;
  localparam logic [2:0] MidAll    = 3'd7;

  // Group 3 last field, instruction bits 3..1
  localparam logic [2:0] EaeNop = 3'd0;
  localparam logic [2:0] EaeScl = 3'd1;
  localparam logic [2:0] EaeMuy = 3'd2;
  localparam logic [2:0] EaeDvi = 3'd3;
  localparam logic [2:0] EaeNmi = 3'd4;
  localparam logic [2:0] EaeShl = 3'd5;
  localparam logic [2:0] EaeAsr = 3'd6;
  localparam logic [2:0] EaeLsr = 3'd7;

endpackage

`default_nettype wire

// File: rtl/core/operate_group_eae_unit.sv
`default_nettype none

// Operate-instruction unit with extended arithmetic element. One item carries the
// instruction, AC, link and the following word; one result item returns AC, link,
// MQ, step counter and the skip, operand-used, halt and invalid flags. MQ and the
// step counter live here and carry over from item to item. Group 1 and group 2
// instructions, SCL, NMI and an overflowing divide are done in the accept cycle and
// need no steps. MUY and DVI share one 13-bit adder/subtractor that handles one
// multiplier or quotient bit per cycle. SHL, ASR and LSR shift one bit position per
// cycle. A new item is taken once the previous result sits in the output register,
// even while it waits there. The user writes the switch register through cfg_we_i /
// cfg_wdata_i only while idle; the block itself does not enforce this.

module operate_group_eae_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ogeae_pkg::WordW-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // instr_word, acc_in, link_in, next_word, zero pad
  input  logic [ogeae_pkg::InW-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // acc_out, link_out, mq_out, step_count_out, skip_next, consumed_next,
  // halt_req, invalid_op, zero pad
  output logic [ogeae_pkg::OutW-1:0]  m_axis_tdata
);
  import ogeae_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic             state_q, state_d;
  logic [2:0]       op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] ac_q, ac_d;
  logic             lk_q, lk_d;
  logic [WordW-1:0] mq_q, mq_d;
  logic [ScW-1:0]   sc_q, sc_d;
  logic [WordW-1:0] nw_q, nw_d;
  logic [3:0]       flags_q, flags_d;
  logic [WordW-1:0] sw_q;
  logic             out_valid_q;
  logic [OutW-1:0]  out_data_q;

  logic [WordW-1:0] in_ir, in_ac, in_nw;
  logic             in_lk;
  logic             accept, finish;

  logic [WordW-1:0] ac_a, mq_a;
  logic             lk_a;
  logic [ScW-1:0]   sc_a;
  logic [2:0]       op_a;
  logic [CntW-1:0]  cnt_a;
  logic             skip_a, used_a, halt_a, bad_a;
  logic [WordW:0]   inc;
  logic             sel;

  logic [WordW:0]   alu_a, alu_b;
  logic             alu_sub;
  logic [WordW+1:0] alu_res;

  assign in_ir = s_axis_tdata[InIrLo +: WordW];
  assign in_ac = s_axis_tdata[InAcLo +: WordW];
  assign in_lk = s_axis_tdata[InLkLo];
  assign in_nw = s_axis_tdata[InNwLo +: WordW];

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign finish        = (state_q == StRun) && (cnt_q == '0)
                         && (!out_valid_q || m_axis_tready);

  // decode and first stage, done in the accept cycle
  always_comb begin
    ac_a   = in_ac;
    lk_a   = in_lk;
    mq_a   = mq_q;
    sc_a   = sc_q;
    op_a   = EaeNop;
    cnt_a  = '0;
    skip_a = 1'b0;
    used_a = 1'b0;
    halt_a = 1'b0;
    bad_a  = 1'b0;
    inc    = '0;
    sel    = 1'b0;
    if (!in_ir[8]) begin
      if (in_ir[7]) ac_a = '0;
      if (in_ir[6]) lk_a = 1'b0;
      if (in_ir[5]) ac_a = ~ac_a;
      if (in_ir[4]) lk_a = ~lk_a;
      if (in_ir[0]) begin
        inc  = {1'b0, ac_a} + {{WordW{1'b0}}, 1'b1};
        ac_a = inc[WordW-1:0];
        lk_a = lk_a ^ inc[WordW];
      end
      if (in_ir[2]) begin
        {lk_a, ac_a} = {ac_a, lk_a};
        if (in_ir[1]) {lk_a, ac_a} = {ac_a, lk_a};
      end
      if (in_ir[3]) begin
        {lk_a, ac_a} = {ac_a[0], lk_a, ac_a[WordW-1:1]};
        if (in_ir[1]) {lk_a, ac_a} = {ac_a[0], lk_a, ac_a[WordW-1:1]};
      end
      if (in_ir[1] && !in_ir[3] && !in_ir[2]) begin
        ac_a = {ac_a[WordW/2-1:0], ac_a[WordW-1:WordW/2]};
      end
    end else if (!in_ir[0]) begin
      sel = (in_ir[4] && in_lk) || (in_ir[5] && (in_ac == '0))
            || (in_ir[6] && in_ac[WordW-1]);
      skip_a = in_ir[3] ? !sel : sel;
      if (in_ir[7]) ac_a = '0;
      if (in_ir[2]) ac_a = ac_a | sw_q;
      halt_a = in_ir[1];
    end else begin
      if (in_ir[7]) ac_a = '0;
      case (in_ir[6:4]) inside
        MidMql:                    mq_a = ac_a;
        MidSca:                    ac_a = ac_a | {{(WordW-ScW){1'b0}}, sc_q};
        MidMqa:                    ac_a = ac_a | mq_q;
        MidSwp: begin
          mq_a = ac_a;
          ac_a = mq_q;
        end
        MidScaMql, MidMqaSca, MidAll: bad_a = 1'b1;
        default: ;
      endcase
      case (in_ir[3:1])
        EaeScl: begin
          sc_a   = ~in_nw[ScW-1:0];
          used_a = 1'b1;
        end
        EaeMuy: begin
          ac_a   = '0;
          op_a   = EaeMuy;
          cnt_a  = MulDivSteps;
          used_a = 1'b1;
        end
        EaeDvi: begin
          used_a = 1'b1;
          if (ac_a >= in_nw) begin
            lk_a = 1'b1;
          end else begin
            lk_a  = 1'b0;
            op_a  = EaeDvi;
            cnt_a = MulDivSteps;
          end
        end
        EaeNmi: bad_a = 1'b1;
        EaeShl: begin
          op_a   = EaeShl;
          cnt_a  = (in_nw >= WordW'(ShlMaxSteps - 1'b1)) ? ShlMaxSteps
                                                         : in_nw[CntW-1:0] + 1'b1;
          used_a = 1'b1;
        end
        EaeAsr, EaeLsr: begin
          op_a   = in_ir[3:1];
          cnt_a  = (in_nw >= WordW'(ShrMaxSteps - 1'b1)) ? ShrMaxSteps
                                                         : in_nw[CntW-1:0] + 1'b1;
          used_a = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // shared adder/subtractor for multiply and divide steps
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (op_q)
      EaeMuy: begin
        alu_a = {1'b0, ac_q};
        alu_b = mq_q[0] ? {1'b0, nw_q} : '0;
      end
      EaeDvi: begin
        alu_a   = {ac_q, mq_q[WordW-1]};
        alu_b   = {1'b0, nw_q};
        alu_sub = 1'b1;
      end
      default: ;
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                      : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    ac_d    = ac_q;
    lk_d    = lk_q;
    mq_d    = mq_q;
    sc_d    = sc_q;
    nw_d    = nw_q;
    flags_d = flags_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          op_d    = op_a;
          cnt_d   = cnt_a;
          ac_d    = ac_a;
          lk_d    = lk_a;
          mq_d    = mq_a;
          sc_d    = sc_a;
          nw_d    = in_nw;
          flags_d = {bad_a, halt_a, used_a, skip_a};
        end
      end
      StRun: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
          case (op_q)
            EaeMuy: begin
              ac_d = alu_res[WordW:1];
              mq_d = {alu_res[0], mq_q[WordW-1:1]};
            end
            EaeDvi: begin
              ac_d = alu_res[WordW+1] ? alu_a[WordW-1:0] : alu_res[WordW-1:0];
              mq_d = {mq_q[WordW-2:0], !alu_res[WordW+1]};
            end
            EaeShl:  {lk_d, ac_d, mq_d} = {ac_q, mq_q, 1'b0};
            EaeAsr:  {ac_d, mq_d} = {ac_q[WordW-1], ac_q, mq_q[WordW-1:1]};
            EaeLsr:  {ac_d, mq_d} = {1'b0, ac_q, mq_q[WordW-1:1]};
            default: ;
          endcase
        end else if (finish) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      op_q        <= EaeNop;
      mq_q        <= '0;
      sc_q        <= '0;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
      mq_q    <= mq_d;
      sc_q    <= sc_d;
      if (cfg_we_i) sw_q <= cfg_wdata_i;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ac_q    <= ac_d;
    lk_q    <= lk_d;
    nw_q    <= nw_d;
    flags_q <= flags_d;
    if (finish) begin
      out_data_q <= {{(OutW-OutBits){1'b0}}, flags_q, sc_q, mq_q, lk_q, ac_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("unit ready right after taking an item");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ShlMaxSteps)
    else $error("step count beyond longest shift");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> m_axis_tvalid && s_axis_tready)
    else $error("finished item not presented");

  a_flag_groups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !((m_axis_tdata[OutBits-4] || m_axis_tdata[OutBits-2])
                        && (m_axis_tdata[OutBits-3] || m_axis_tdata[OutBits-1])))
    else $error("group 2 and group 3 flags both set");
`endif

endmodule

`default_nettype wire

// File: sim/ogeae_checker.sv
`timescale 1ns / 1ps

module ogeae_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ogeae_pkg::WordW-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  // instr_word, acc_in, link_in, next_word, zero pad
  input  logic [ogeae_pkg::InW-1:0]   s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // acc_out, link_out, mq_out, step_count_out, skip_next, consumed_next,
  // halt_req, invalid_op, zero pad
  input  logic [ogeae_pkg::OutW-1:0]  m_axis_tdata,
  output int                          fail_count_o,
  output int                          results_due_o
);

  import ogeae_pkg::*;

  localparam int OutAccLo  = 0;
  localparam int OutLinkLo = OutAccLo + WordW;
  localparam int OutMqLo   = OutLinkLo + 1;
  localparam int OutScLo   = OutMqLo + WordW;
  localparam int OutSkipLo = OutScLo + ScW;
  localparam int OutUsedLo = OutSkipLo + 1;
  localparam int OutHaltLo = OutUsedLo + 1;
  localparam int OutBadLo  = OutHaltLo + 1;

  typedef struct packed {
    logic [WordW-1:0] acc;
    logic             link;
    logic [WordW-1:0] mq;
    logic [ScW-1:0]   steps;
    logic             skip;
    logic             used;
    logic             halt;
    logic             invalid;
  } op_result_t;

  logic [WordW-1:0] switch_model;
  logic [WordW-1:0] mq_model;
  logic [ScW-1:0]   step_model;
  op_result_t       pending_results[$];

  function automatic op_result_t run_operate(input logic [WordW-1:0] ir,
                                             input logic [WordW-1:0] ac_in,
                                             input logic lk_in,
                                             input logic [WordW-1:0] nw);
    logic [WordW-1:0]   ac;
    logic [WordW-1:0]   tmp;
    logic               lk;
    logic               nl;
    logic               hit;
    logic [2*WordW-1:0] pair;
    logic [4*WordW-1:0] wide;
    logic [WordW:0]     cnt;
    int                 reps;
    op_result_t         r;
    ac = ac_in;
    lk = lk_in;
    r  = '0;
    if (!ir[8]) begin
      if (ir[7]) ac = '0;
      if (ir[6]) lk = 1'b0;
      if (ir[5]) ac = ~ac;
      if (ir[4]) lk = ~lk;
      if (ir[0]) begin
        ac = ac + 1'b1;
        if (ac == '0) lk = ~lk;
      end
      reps = ir[1] ? 2 : 1;
      if (ir[2]) begin
        for (int i = 0; i < reps; i++) begin
          nl = ac[11];
          ac = {ac[10:0], lk};
          lk = nl;
        end
      end
      if (ir[3]) begin
        for (int i = 0; i < reps; i++) begin
          nl = ac[0];
          ac = {lk, ac[11:1]};
          lk = nl;
        end
      end
      if (ir[1] && !ir[2] && !ir[3]) ac = {ac[5:0], ac[11:6]};
    end else if (!ir[0]) begin
      hit = (ir[4] && lk) || (ir[5] && ac == '0) || (ir[6] && ac[11]);
      r.skip = hit ^ ir[3];
      if (ir[7]) ac = '0;
      if (ir[2]) ac = ac | switch_model;
      r.halt = ir[1];
    end else begin
      if (ir[7]) ac = '0;
      case (ir[6:4])
        MidMql: mq_model = ac;
        MidSca: ac = ac | WordW'(step_model);
        MidMqa: ac = ac | mq_model;
        MidSwp: begin
          tmp = ac;
          ac = mq_model;
          mq_model = tmp;
        end
        MidScaMql, MidMqaSca, MidAll: r.invalid = 1'b1;
        default: ;
      endcase
      pair = {ac, mq_model};
      cnt = {1'b0, nw} + 1'b1;
      r.used = 1'b1;
      case (ir[3:1])
        EaeScl: step_model = ~nw[ScW-1:0];
        EaeMuy: {ac, mq_model} = (2*WordW)'(nw) * (2*WordW)'(mq_model);
        EaeDvi: begin
          if (ac >= nw) begin
            lk = 1'b1;
          end else begin
            mq_model = WordW'(pair / (2*WordW)'(nw));
            ac = WordW'(pair % (2*WordW)'(nw));
            lk = 1'b0;
          end
        end
        EaeShl: begin
          if (cnt >= 25) begin
            ac = '0;
            mq_model = '0;
            lk = 1'b0;
          end else begin
            wide = {{(2*WordW){1'b0}}, pair} << cnt;
            lk = wide[2*WordW];
            {ac, mq_model} = wide[2*WordW-1:0];
          end
        end
        EaeAsr: begin
          if (cnt > 24) cnt = (WordW+1)'(24);
          wide = {{(2*WordW){pair[2*WordW-1]}}, pair} >> cnt;
          {ac, mq_model} = wide[2*WordW-1:0];
        end
        EaeLsr: begin
          if (cnt >= 24) {ac, mq_model} = '0;
          else {ac, mq_model} = pair >> cnt;
        end
        EaeNmi: begin
          r.invalid = 1'b1;
          r.used = 1'b0;
        end
        default: r.used = 1'b0;
      endcase
    end
    r.acc   = ac;
    r.link  = lk;
    r.mq    = mq_model;
    r.steps = step_model;
    return r;
  endfunction

  function automatic op_result_t unpack_result(input logic [OutW-1:0] td);
    op_result_t r;
    r.acc     = td[OutAccLo +: WordW];
    r.link    = td[OutLinkLo];
    r.mq      = td[OutMqLo +: WordW];
    r.steps   = td[OutScLo +: ScW];
    r.skip    = td[OutSkipLo];
    r.used    = td[OutUsedLo];
    r.halt    = td[OutHaltLo];
    r.invalid = td[OutBadLo];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    op_result_t want;
    op_result_t got;
    if (!rst_ni) begin
      switch_model = '0;
      mq_model = '0;
      step_model = '0;
      pending_results.delete();
      fail_count_o = 0;
      results_due_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_result(m_axis_tdata);
        if (pending_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: expected no item, actual acc=%o lk=%0b mq=%o sc=%0d", $time,
                   got.acc, got.link, got.mq, got.steps);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            $display({"%0t: expected acc=%o lk=%0b mq=%o sc=%0d",
                      " skip=%0b used=%0b halt=%0b bad=%0b"},
                     $time, want.acc, want.link, want.mq, want.steps, want.skip,
                     want.used, want.halt, want.invalid);
            $display({"%0t: actual   acc=%o lk=%0b mq=%o sc=%0d",
                      " skip=%0b used=%0b halt=%0b bad=%0b"},
                     $time, got.acc, got.link, got.mq, got.steps, got.skip,
                     got.used, got.halt, got.invalid);
          end
        end
      end
      if (cfg_we_i) switch_model = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(run_operate(s_axis_tdata[InIrLo +: WordW],
                                              s_axis_tdata[InAcLo +: WordW],
                                              s_axis_tdata[InLkLo],
                                              s_axis_tdata[InNwLo +: WordW]));
      results_due_o = pending_results.size();
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  import ogeae_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 40;
  localparam int PhaseItems  = 575;

  localparam logic [WordW-1:0] G1Base = 12'o7000;
  localparam logic [WordW-1:0] G2Base = 12'o7400;
  localparam logic [WordW-1:0] BitCla = 12'o0200;
  localparam logic [WordW-1:0] BitCll = 12'o0100;
  localparam logic [WordW-1:0] BitCma = 12'o0040;
  localparam logic [WordW-1:0] BitCml = 12'o0020;
  localparam logic [WordW-1:0] BitRar = 12'o0010;
  localparam logic [WordW-1:0] BitRal = 12'o0004;
  localparam logic [WordW-1:0] BitBsw = 12'o0002;
  localparam logic [WordW-1:0] BitIac = 12'o0001;
  localparam logic [WordW-1:0] BitSma = 12'o0100;
  localparam logic [WordW-1:0] BitSza = 12'o0040;
  localparam logic [WordW-1:0] BitSnl = 12'o0020;
  localparam logic [WordW-1:0] BitRev = 12'o0010;
  localparam logic [WordW-1:0] BitOsr = 12'o0004;
  localparam logic [WordW-1:0] BitHlt = 12'o0002;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WordW-1:0]  cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [InW-1:0]    s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OutW-1:0]   m_axis_tdata;
  int                fail_count;
  int                results_due;
  int                src_idle_pct;
  int                snk_idle_pct;
  int                stall_cycles;
  logic              hold_req;

  always #5 clk_i = ~clk_i;

  operate_group_eae_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  ogeae_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .results_due_o(results_due)
  );

  function automatic logic [WordW-1:0] eae(input logic cla, input logic [2:0] mid,
                                           input logic [2:0] last);
    return {4'b1111, cla, mid, last, 1'b1};
  endfunction

  function automatic logic [InW-1:0] pack_op(input logic [WordW-1:0] ir,
                                             input logic [WordW-1:0] ac,
                                             input logic lk,
                                             input logic [WordW-1:0] nw);
    logic [InW-1:0] td;
    td = '0;
    td[InIrLo +: WordW] = ir;
    td[InAcLo +: WordW] = ac;
    td[InLkLo]          = lk;
    td[InNwLo +: WordW] = nw;
    return td;
  endfunction

  function automatic logic [InW-1:0] random_op();
    logic [WordW-1:0] ir;
    logic [WordW-1:0] ac;
    logic [WordW-1:0] nw;
    logic             lk;
    int               sel;
    ir  = WordW'($urandom);
    ac  = WordW'($urandom);
    nw  = WordW'($urandom);
    lk  = 1'($urandom);
    sel = $urandom_range(99);
    if ($urandom_range(9) != 0) ir[11:9] = 3'b111;
    if (sel < 30) begin
      ir[8] = 1'b0;
    end else if (sel < 50) begin
      ir[8] = 1'b1;
      ir[0] = 1'b0;
    end else begin
      ir[8] = 1'b1;
      ir[0] = 1'b1;
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(4))
          0: ir[6:4] = MidNone;
          1: ir[6:4] = MidMql;
          2: ir[6:4] = MidSca;
          3: ir[6:4] = MidMqa;
          default: ir[6:4] = MidSwp;
        endcase
      end
      if ((ir[3:1] == EaeShl || ir[3:1] == EaeAsr || ir[3:1] == EaeLsr) &&
          $urandom_range(3) != 0)
        nw = WordW'($urandom_range(26));
      if (ir[3:1] == EaeDvi && $urandom_range(4) != 0) begin
        nw = WordW'($urandom_range(4095, 1));
        ac = WordW'($urandom_range(nw - 1));
        ir[7] = 1'b0;
      end
    end
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: ac = 12'o0000;
        1: ac = 12'o7777;
        2: ac = 12'o4000;
        default: ac = 12'o3777;
      endcase
    end
    return pack_op(ir, ac, lk, nw);
  endfunction

  task automatic push_item(input logic [InW-1:0] td);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= td;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_switch(input logic [WordW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int hold_at);
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      push_item(random_op());
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    src_idle_pct  = 32;
    snk_idle_pct  = 52;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_switch(12'o1234);
    push_item(pack_op(G1Base | BitCla | BitCll, 12'o5555, 1'b1, 12'o0000));
    push_item(pack_op(G1Base | BitCma | BitCml, 12'o0000, 1'b0, 12'o7777));
    push_item(pack_op(G1Base | BitIac, 12'o7777, 1'b0, 12'o0000));
    push_item(pack_op(G1Base | BitRal | BitRar, 12'o4001, 1'b1, 12'o0000));
    push_item(pack_op(G1Base | BitRal | BitBsw, 12'o6001, 1'b0, 12'o0000));
    push_item(pack_op(G1Base | BitRar | BitBsw, 12'o0003, 1'b1, 12'o0000));
    push_item(pack_op(G1Base | BitBsw, 12'o0077, 1'b0, 12'o0000));
    push_item(pack_op(G1Base | BitCla | BitCma | BitIac | BitRal, 12'o0001, 1'b1, 12'o0));
    push_item(pack_op(G2Base | BitSma | BitSza | BitSnl, 12'o4000, 1'b0, 12'o0000));
    push_item(pack_op(G2Base | BitRev | BitSma | BitSza, 12'o0000, 1'b1, 12'o0000));
    push_item(pack_op(G2Base | BitRev | BitHlt, 12'o2525, 1'b0, 12'o0000));
    push_item(pack_op(G2Base | BitCla | BitOsr | BitSnl, 12'o7777, 1'b1, 12'o0000));
    push_item(pack_op(eae(1'b0, MidMql, EaeNop), 12'o7777, 1'b0, 12'o0000));
    push_item(pack_op(eae(1'b0, MidNone, EaeMuy), 12'o0000, 1'b1, 12'o7777));
    push_item(pack_op(eae(1'b0, MidNone, EaeDvi), 12'o0012, 1'b1, 12'o0100));
    push_item(pack_op(eae(1'b0, MidNone, EaeDvi), 12'o0000, 1'b0, 12'o0000));
    push_item(pack_op(eae(1'b0, MidNone, EaeDvi), 12'o5000, 1'b0, 12'o4000));
    push_item(pack_op(eae(1'b1, MidNone, EaeScl), 12'o1111, 1'b0, 12'o0000));
    push_item(pack_op(eae(1'b1, MidSca, EaeNop), 12'o7777, 1'b0, 12'o0000));
    push_item(pack_op(eae(1'b0, MidSwp, EaeNmi), 12'o1234, 1'b1, 12'o0007));
    push_item(pack_op(eae(1'b0, MidMqa, EaeShl), 12'o0001, 1'b0, 12'o0027));
    push_item(pack_op(eae(1'b0, MidNone, EaeShl), 12'o7777, 1'b0, 12'o0030));
    push_item(pack_op(eae(1'b0, MidMql, EaeAsr), 12'o4000, 1'b0, 12'o7777));
    push_item(pack_op(eae(1'b0, MidScaMql, EaeLsr), 12'o7777, 1'b1, 12'o0026));
    push_item(pack_op(eae(1'b0, MidMqaSca, EaeLsr), 12'o7777, 1'b1, 12'o0027));
    push_item(pack_op(eae(1'b1, MidAll, EaeScl), 12'o7777, 1'b0, 12'o7777));
    random_phase(PhaseItems, 200);
    drain();

    set_switch(12'o7777);
    src_idle_pct = 52;
    snk_idle_pct = 32;
    random_phase(PhaseItems, -1);
    drain();

    set_switch(12'o0000);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase(PhaseItems / 2, 100);
    drain();

    set_switch(WordW'($urandom));
    random_phase(PhaseItems / 2, -1);
    drain();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
